@@ rtl/endpoint_connection_admission_table_unit_assert.svh @@
// Assertion macros for the endpoint connection admission table.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef ENDPOINT_CONNECTION_ADMISSION_TABLE_UNIT_ASSERT_SVH
`define ENDPOINT_CONNECTION_ADMISSION_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define ECAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ecat check failed");

// Next-cycle implication, checked only out of reset.
`define ECAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ecat check failed");

`endif

@@ rtl/ecat_pkg.sv @@
// Shared types, sizes and codes for the endpoint connection admission table.
// No dependencies; every other module imports it.
package ecat_pkg;

    localparam int TABLE_ENTRIES       = 64;
    localparam int KEY_BITS            = 64;
    localparam int COUNT_BITS          = 10;
    localparam int DENIAL_BITS         = 16;
    localparam int UNLIMITED_AVAILABLE = 64;
    localparam int CMP_BITS            = 17;

    typedef logic [KEY_BITS-1:0]    t_key;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [DENIAL_BITS-1:0] t_denial;
    typedef logic [TABLE_ENTRIES-1:0] t_vec;

    localparam t_count  COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam t_denial DENIAL_MAX = {DENIAL_BITS{1'b1}};

    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;

    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_AT_LIMIT   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_ALREADY    = 3'd3;
    localparam logic [2:0] ST_RELEASED   = 3'd4;
    localparam logic [2:0] ST_IGNORED    = 3'd5;
    localparam logic [2:0] ST_UNBALANCED = 3'd6;
    localparam logic [2:0] ST_QUERY      = 3'd7;

    typedef struct packed {
        t_count  held;
        t_count  peak;
        t_denial denials;
    } t_entry;

    typedef struct packed {
        logic write;
        logic load;
        logic drop;
    } t_cell_cmd;

    typedef struct packed {
        logic valid;
        logic hit;
        logic idle;
    } t_cell_stat;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] endpoint_key;
        logic [9:0]  connection_limit;
        logic        lease_held;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  held_count;
        logic [9:0]  available;
        logic [9:0]  peak_count;
        logic [15:0] denial_count;
    } t_result;

endpackage

@@ rtl/ecat_cell.sv @@
// One table slot: valid flag, key and counters, with its own key compare.
// Depends on ecat_pkg.
module ecat_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecat_pkg::t_key     i_key,
    input  ecat_pkg::t_cell_cmd i_cmd,
    input  ecat_pkg::t_entry   i_wdata,
    output ecat_pkg::t_cell_stat o_stat,
    output ecat_pkg::t_entry   o_entry
);
    import ecat_pkg::*;

    logic   r_valid;
    t_key   r_key;
    t_entry r_entry;

    // Load wins over drop: a compacted slot may be refilled in the same transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_cmd.drop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
        end
        if (i_cmd.load || i_cmd.write) begin
            r_entry <= i_wdata;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.hit   = r_valid && (r_key == i_key);
    assign o_stat.idle  = (r_entry.held == '0);
    assign o_entry      = r_entry;

endmodule

@@ rtl/endpoint_connection_admission_table_unit.sv @@
// Top level of the endpoint connection admission table: a row of slot cells
// plus the lookup/update sequencer. Depends on ecat_pkg and ecat_cell.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      i_req    (t_request)
// result    out        o_result_valid strobe     o_result (t_result)
//
// An item runs through a lookup cycle (all slots compare the key in
// parallel, compaction and free-slot pick) and an update cycle (one
// read-modify-write of the chosen slot). busy is high during lookup only, so
// a new request is taken in the update cycle, while the last one finishes.
// The result strobe shows in the cycle after the update cycle and is
// never held off. Reset clears all slot valid flags at once; no clearing pass.
module endpoint_connection_admission_table_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ecat_pkg::t_request i_req,
    output logic              o_result_valid,
    output ecat_pkg::t_result o_result
);
    import ecat_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LOOK   = 2'd1;
    localparam logic [1:0] PH_UPDATE = 2'd2;

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    t_request   r_req;
    logic       w_accept;

    // Slot row
    t_key       w_key;
    t_cell_stat w_stat  [TABLE_ENTRIES];
    t_entry     w_entry [TABLE_ENTRIES];
    t_cell_cmd  w_cmd   [TABLE_ENTRIES];
    t_entry     w_wdata;

    // Lookup cycle
    t_vec   w_valid_vec, w_hit_vec, w_idle_vec, w_drop_vec, w_free_vec, w_ins_oh;
    t_entry w_sel;
    logic   w_full;

    logic   r_found;
    t_vec   r_hit_oh;
    t_vec   r_ins_oh;
    logic   r_ins_ok;
    t_vec   r_drop_vec;
    t_entry r_sel;

    // Update cycle
    logic                w_upd;
    logic                w_acq_new;
    logic                w_miss_ins;
    logic                w_present;
    logic                w_write;
    logic                w_grant;
    logic [2:0]          w_status;
    t_entry              w_base;
    t_entry              w_new;
    t_count              w_held_inc;
    logic [CMP_BITS-1:0] w_held_x;
    logic [CMP_BITS-1:0] w_lim_x;
    logic [9:0]          w_avail;
    t_entry              w_shown;

    t_result r_result;
    logic    r_result_valid;

    // ------------------------------------------------------------------
    // Handshake and sequencer
    // ------------------------------------------------------------------
    assign busy     = (r_phase == PH_LOOK);
    assign w_accept = start && !busy;
    assign w_upd    = (r_phase == PH_UPDATE);

    always_comb begin
        unique case (r_phase)
            PH_IDLE:   n_phase = w_accept ? PH_LOOK : PH_IDLE;
            PH_LOOK:   n_phase = PH_UPDATE;
            PH_UPDATE: n_phase = w_accept ? PH_LOOK : PH_IDLE;
            default:   n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Hold the request for the lookup and update cycles.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    // ------------------------------------------------------------------
    // Slot row: every cell compares the held request key each cycle
    // ------------------------------------------------------------------
    assign w_key = r_req.endpoint_key[KEY_BITS-1:0];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ecat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (w_key),
            .i_cmd   (w_cmd[g]),
            .i_wdata (w_wdata),
            .o_stat  (w_stat[g]),
            .o_entry (w_entry[g])
        );
        assign w_valid_vec[g] = w_stat[g].valid;
        assign w_hit_vec[g]   = w_stat[g].hit;
        assign w_idle_vec[g]  = w_stat[g].idle;

        // Drop idle slots only when a new key meets a full table.
        assign w_cmd[g].drop  = w_upd && w_miss_ins && r_drop_vec[g];
        assign w_cmd[g].load  = w_upd && w_miss_ins && r_ins_ok && r_ins_oh[g];
        assign w_cmd[g].write = w_upd && w_write && r_found && r_hit_oh[g];
    end

    // ------------------------------------------------------------------
    // Lookup: hit select, compaction set, lowest free slot
    // ------------------------------------------------------------------
    // Keys are unique among valid slots, so at most one hit; OR the masked entries.
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_sel = w_sel | (w_hit_vec[i] ? w_entry[i] : '0);
        end
    end

    assign w_full     = &w_valid_vec;
    assign w_drop_vec = w_full ? (w_valid_vec & w_idle_vec) : '0;
    assign w_free_vec = ~w_valid_vec | w_drop_vec;
    // Isolate the lowest set bit of the free vector.
    assign w_ins_oh   = w_free_vec & (~w_free_vec + t_vec'(1));

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_LOOK) begin
            r_found    <= |w_hit_vec;
            r_hit_oh   <= w_hit_vec;
            r_sel      <= w_sel;
            r_ins_oh   <= w_ins_oh;
            r_ins_ok   <= |w_free_vec;
            r_drop_vec <= w_drop_vec;
        end
    end

    // ------------------------------------------------------------------
    // Update: decide, modify the chosen slot, form the result
    // ------------------------------------------------------------------
    assign w_acq_new  = (r_req.kind == KIND_ACQUIRE) && !r_req.lease_held;
    assign w_miss_ins = w_acq_new && !r_found;
    assign w_present  = r_found || (w_miss_ins && r_ins_ok);
    assign w_base     = r_found ? r_sel : '0;
    assign w_held_inc = w_base.held + t_count'(1);
    assign w_lim_x    = CMP_BITS'(r_req.connection_limit);

    assign w_grant = ((r_req.connection_limit == '0)
                      || (CMP_BITS'(w_base.held) < w_lim_x))
                     && (w_base.held != COUNT_MAX);

    always_comb begin
        w_new    = w_base;
        w_write  = 1'b0;
        w_status = ST_IGNORED;
        priority if (r_req.kind == KIND_ACQUIRE) begin
            if (r_req.lease_held) begin
                w_status = ST_ALREADY;
            end else if (!w_present) begin
                w_status = ST_TABLE_FULL;
            end else if (w_grant) begin
                w_write    = 1'b1;
                w_new.held = w_held_inc;
                if (w_held_inc > w_base.peak) begin
                    w_new.peak = w_held_inc;
                end
                w_status = ST_GRANTED;
            end else begin
                w_write = 1'b1;
                if (w_base.denials != DENIAL_MAX) begin
                    w_new.denials = w_base.denials + t_denial'(1);
                end
                w_status = ST_AT_LIMIT;
            end
        end else if (r_req.kind == KIND_RELEASE) begin
            if (!r_req.lease_held) begin
                w_status = ST_IGNORED;
            end else if (r_found && (w_base.held != '0)) begin
                w_write    = 1'b1;
                w_new.held = w_base.held - t_count'(1);
                w_status   = ST_RELEASED;
            end else begin
                w_status = ST_UNBALANCED;
            end
        end else if (r_req.kind == KIND_QUERY) begin
            w_status = ST_QUERY;
        end else begin
            w_status = ST_IGNORED;
        end
    end

    assign w_wdata  = w_new;
    assign w_shown  = w_present ? w_new : '0;
    assign w_held_x = CMP_BITS'(w_shown.held);

    always_comb begin
        if (r_req.connection_limit == '0) begin
            w_avail = 10'(UNLIMITED_AVAILABLE);
        end else if (w_lim_x > w_held_x) begin
            w_avail = 10'(w_lim_x - w_held_x);
        end else begin
            w_avail = '0;
        end
    end

    // Register the result; it shows for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_result.status       <= w_status;
            r_result.held_count   <= 10'(w_shown.held);
            r_result.available    <= w_avail;
            r_result.peak_count   <= 10'(w_shown.peak);
            r_result.denial_count <= 16'(w_shown.denials);
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

@@ rtl/ecat_checker.sv @@
// Port-level checks for the endpoint connection admission table, bound to the top.
// Depends on ecat_pkg and the assertion macro header.
`include "endpoint_connection_admission_table_unit_assert.svh"

module ecat_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input ecat_pkg::t_result o_result
);
    import ecat_pkg::*;

    // Every transfer yields its result strobe after its lookup and update cycles.
    `ECAT_ASSERT_IMP(a_result_after_accept, start && !busy, ##3 o_result_valid)
    // busy is always low in the cycle after a lookup cycle.
    `ECAT_ASSERT_NXT(a_busy_single, busy, !busy)
    // A transfer always enters the lookup cycle.
    `ECAT_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
    // A table-full refusal reports no endpoint statistics.
    `ECAT_ASSERT_IMP(a_full_no_stats, o_result_valid && (o_result.status == ST_TABLE_FULL),
        (o_result.held_count == '0) && (o_result.peak_count == '0)
        && (o_result.denial_count == '0))

endmodule

bind endpoint_connection_admission_table_unit ecat_checker u_ecat_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
